@@ rtl/rbd_pkg.sv @@
`timescale 1ns / 1ps

package rbd_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned COUNT_W = 10;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RESP = 1'b1
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    status_t                  status;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

@@ rtl/rbd_ram.sv @@
`timescale 1ns / 1ps

module rbd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/rbd_ctrl.sv @@
`timescale 1ns / 1ps

module rbd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rbd_pkg::dp_sts_t   sts,
  output rbd_pkg::ctrl_cmd_t cmd
);

  import rbd_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_RESP;
        end
      end
      S_RESP: begin
        // The store read issued at accept is ready now; wait only for the output register.
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/rbd_dp.sv @@
`timescale 1ns / 1ps

module rbd_dp #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rbd_pkg::in_item_t   in_data,
  input  rbd_pkg::ctrl_cmd_t  cmd,
  output rbd_pkg::dp_sts_t    sts,
  output logic                out_valid,
  input  logic                out_ready,
  output rbd_pkg::out_item_t  out_data
);

  import rbd_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  status_t       pend_status_r, pend_status_nxt;
  logic          pend_rd_r, pend_rd_nxt;
  logic          out_valid_r;
  out_item_t     out_data_r;

  logic                  ram_en;
  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic          empty;
  logic          full;
  logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic signed [DATA_W-1:0] rd_ext;
  logic signed [DATA_W-1:0] res_data;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == LAST_SLOT);
  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + AW'(1);
  assign head_dec = (head_r == '0) ? LAST_SLOT : head_r - AW'(1);
  assign tail_inc = (tail_r == LAST_SLOT) ? '0 : tail_r + AW'(1);
  assign tail_dec = (tail_r == '0) ? LAST_SLOT : tail_r - AW'(1);

  // Pushed words are sign-extended or cut to the element width.
  assign ram_wdata = DATA_WIDTH'(in_data.value);

  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    cnt_nxt         = cnt_r;
    pend_status_nxt = pend_status_r;
    pend_rd_nxt     = pend_rd_r;
    ram_en          = 1'b0;
    ram_we          = 1'b0;
    ram_addr        = head_r;
    if (cmd.accept) begin
      pend_status_nxt = ST_OK;
      pend_rd_nxt     = 1'b0;
      case (in_data.op)
        OP_PUSH_FRONT: begin
          if (full) begin
            pend_status_nxt = ST_FULL;
          end else begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ram_addr = head_r;
            head_nxt = head_dec;
            cnt_nxt  = cnt_r + AW'(1);
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            pend_status_nxt = ST_FULL;
          end else begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ram_addr = tail_inc;
            tail_nxt = tail_inc;
            cnt_nxt  = cnt_r + AW'(1);
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            pend_status_nxt = ST_EMPTY;
          end else begin
            ram_en      = 1'b1;
            ram_addr    = head_inc;
            pend_rd_nxt = 1'b1;
            head_nxt    = head_inc;
            cnt_nxt     = cnt_r - AW'(1);
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            pend_status_nxt = ST_EMPTY;
          end else begin
            ram_en      = 1'b1;
            ram_addr    = tail_r;
            pend_rd_nxt = 1'b1;
            tail_nxt    = tail_dec;
            cnt_nxt     = cnt_r - AW'(1);
          end
        end
        OP_PEEK_FRONT: begin
          if (empty) begin
            pend_status_nxt = ST_EMPTY;
          end else begin
            ram_en      = 1'b1;
            ram_addr    = head_inc;
            pend_rd_nxt = 1'b1;
          end
        end
        OP_PEEK_BACK: begin
          if (empty) begin
            pend_status_nxt = ST_EMPTY;
          end else begin
            ram_en      = 1'b1;
            ram_addr    = tail_r;
            pend_rd_nxt = 1'b1;
          end
        end
        default: begin
          pend_status_nxt = ST_OK;
        end
      endcase
    end
  end

  rbd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign rd_ext = DATA_W'(signed'(ram_rdata));

  always_comb begin
    if (pend_rd_r) begin
      res_data = rd_ext;
    end else if (pend_status_r == ST_EMPTY) begin
      res_data = '1;
    end else begin
      res_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The count register already holds the value after the pending operation.
  always_ff @(posedge clk) begin
    pend_status_r <= pend_status_nxt;
    pend_rd_r     <= pend_rd_nxt;
    if (cmd.load_out) begin
      out_data_r.data     <= res_data;
      out_data_r.status   <= pend_status_r;
      out_data_r.count    <= COUNT_W'(cnt_r);
      out_data_r.is_empty <= (cnt_r == '0);
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

@@ rtl/ring_buffer_deque.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Word
// in_      input      in_valid / in_ready    in_data  (op, value)
// out_     output     out_valid / out_ready  out_data (data, status, count, is_empty)
//
// The accept cycle updates the pointers and issues the single store access, if any;
// the response state then loads the registered read into the output register once
// it is free. A new operation is accepted only after the previous result is loaded.
// Reset (rst_n low, synchronous) empties the deque with no clearing pass. A stalled
// output holds its word while the next one is accepted.

module ring_buffer_deque #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rbd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rbd_pkg::out_item_t out_data
);

  import rbd_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  rbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rbd_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
